FILE: design/ias_pkg.sv
// Shared types for the integer array sorter: cell element and controller states.
package ias_pkg;

	localparam int DataW = 32;

	typedef struct packed {
		logic                    vld;
		logic signed [DataW-1:0] val;
	} elem_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_FLUSH,
		ST_DRAIN
	} state_t;

endpackage

FILE: design/ias_cell.sv
// One sorting cell: keeps the smallest value seen and forwards the rest to its right neighbor.
module ias_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  ias_pkg::elem_t from_left,
	input  ias_pkg::elem_t from_right,
	input  logic          shift_en,
	output ias_pkg::elem_t held,
	output ias_pkg::elem_t pass
);

	ias_pkg::elem_t held_q;
	ias_pkg::elem_t pass_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			pass_q <= '0;
		end else if (shift_en) begin
			held_q     <= from_right;
			pass_q.vld <= 1'b0;
		end else if (from_left.vld && held_q.vld) begin
			if (from_left.val < held_q.val) begin
				held_q.val <= from_left.val;
				pass_q     <= held_q;
			end else begin
				pass_q <= from_left;
			end
		end else begin
			if (from_left.vld) begin
				held_q <= from_left;
			end
			pass_q.vld <= 1'b0;
		end
	end

	assign held = held_q;
	assign pass = pass_q;

endmodule

FILE: design/integer_array_sorter.sv
// Top level of the integer array sorter: a row of sorting cells and its batch controller.
//
// Input transfers carry data_value and last_item. Values enter the first cell of the
// row, one per cycle, and ripple right; each cell keeps the smallest value it has
// seen. Values that arrive while MAX_ELEMENTS are already held are dropped, but a
// dropped item marked last still closes the batch. in_ready is low from the end of a
// batch until its final result has been transferred.
// After the last input transfer the row settles until no cell passes a value on. The
// results then leave the first cell in ascending order, one per cycle while
// out_ready is high, with last_out on the largest value.
// When the receiver stalls, the row holds and sorted_value and last_out stay steady.
// Reset empties every cell and clears the element count; no clearing pass is needed.
module integer_array_sorter #(
	parameter int MAX_ELEMENTS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] data_value,
	input  logic               last_item,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] sorted_value,
	output logic               last_out
);

	localparam int CntW = $clog2(MAX_ELEMENTS + 1);

	ias_pkg::state_t state_q;
	ias_pkg::state_t state_next;
	logic [CntW-1:0] count_q;

	ias_pkg::elem_t held [MAX_ELEMENTS];
	ias_pkg::elem_t pass [MAX_ELEMENTS];
	ias_pkg::elem_t left_in [MAX_ELEMENTS];
	ias_pkg::elem_t right_in [MAX_ELEMENTS];

	logic in_fire;
	logic room;
	logic shift_en;
	logic any_pass;

	assign in_ready = (state_q == ias_pkg::ST_LOAD);
	assign in_fire  = in_valid && in_ready;
	assign room     = (count_q < CntW'(MAX_ELEMENTS));

	assign out_valid    = (state_q == ias_pkg::ST_DRAIN) && held[0].vld;
	assign sorted_value = held[0].val;
	assign last_out     = !held[1].vld;
	assign shift_en     = out_valid && out_ready;

	always_comb begin
		any_pass = 1'b0;
		for (int i = 0; i < MAX_ELEMENTS; i++) begin
			any_pass = any_pass | pass[i].vld;
		end
	end

	generate
		for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
			if (i == 0) begin : g_first
				assign left_in[i] = '{vld: in_fire && room, val: data_value};
			end else begin : g_mid
				assign left_in[i] = pass[i-1];
			end
			if (i == MAX_ELEMENTS - 1) begin : g_end
				assign right_in[i] = '0;
			end else begin : g_inner
				assign right_in[i] = held[i+1];
			end
			ias_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.from_left (left_in[i]),
				.from_right(right_in[i]),
				.shift_en  (shift_en),
				.held      (held[i]),
				.pass      (pass[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ias_pkg::ST_LOAD;
			count_q <= '0;
		end else begin
			state_q <= state_next;
			if (in_fire && room) begin
				count_q <= count_q + CntW'(1);
			end else if (shift_en && last_out) begin
				count_q <= '0;
			end
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ias_pkg::ST_LOAD: begin
				if (in_fire && last_item) begin
					state_next = ias_pkg::ST_FLUSH;
				end
			end
			ias_pkg::ST_FLUSH: begin
				if (!any_pass) begin
					state_next = ias_pkg::ST_DRAIN;
				end
			end
			ias_pkg::ST_DRAIN: begin
				if (shift_en && last_out) begin
					state_next = ias_pkg::ST_LOAD;
				end
			end
			default: begin
				state_next = ias_pkg::ST_LOAD;
			end
		endcase
	end

endmodule
